[hw/rtl/b64c_pkg.sv]
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared types, constants and character tables of the base64 codec.
// ----------------------------------------------------------------------------
`default_nettype none

package b64c_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int MAX_RESULTS = 4;
   localparam int RIDX_W      = $clog2(MAX_RESULTS);

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   typedef enum logic {
      DIR_ENCODE = 1'b0,
      DIR_DECODE = 1'b1
   } dir_type;

   typedef enum logic [1:0] {
      PHASE_START = 2'd0,
      PHASE_ONE   = 2'd1,
      PHASE_TWO   = 2'd2,
      PHASE_THREE = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0] in_value;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_value;
      logic       out_valid;
      logic       out_last;
      logic       bad_char;
   } rsp_type;

   // One accepted item, expanded into the words it produces
   typedef struct packed {
      rsp_type [MAX_RESULTS-1:0] res;
      logic    [RIDX_W-1:0]      final_idx;
   } cmd_type;

   typedef struct packed {
      phase_type phase;
      dir_type   direction;
   } front_status_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] sextet;
   } sextet_type;

   function automatic logic [7:0] enc_char(input logic [5:0] s);
      logic [7:0] wide;
      wide = {2'b00, s};
      if (s < 6'd26)
         return 8'(wide + 8'h41);
      else if (s < 6'd52)
         return 8'(wide + 8'h47);        // 'a' - 26
      else if (s < 6'd62)
         return 8'(wide - 8'h04);        // '0' - 52
      else if (s == 6'd62)
         return 8'h2B;
      else
         return 8'h2F;
   endfunction

   function automatic sextet_type dec_char(input logic [7:0] c);
      sextet_type r;
      logic [7:0] t;
      r = '{hit: 1'b1, sextet: 6'd0};
      t = 8'h00;
      if (c >= 8'h41 && c <= 8'h5A) begin
         t = 8'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         t = 8'(c - 8'h47);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         t = 8'(c + 8'h04);
      end else if (c == 8'h2B) begin
         t = 8'd62;
      end else if (c == 8'h2F) begin
         t = 8'd63;
      end else begin
         r.hit = 1'b0;
      end
      r.sextet = t[5:0];
      return r;
   endfunction

   function automatic rsp_type data_word(input logic [7:0] v);
      return '{out_value: v, out_valid: 1'b1, out_last: 1'b0, bad_char: 1'b0};
   endfunction

endpackage

`default_nettype wire

[hw/rtl/b64c_if.sv]
// ----------------------------------------------------------------------------
// b64c_if
// Valid/ready channels of the base64 codec: request and response.
// ----------------------------------------------------------------------------
`default_nettype none

interface b64c_req_if import b64c_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface b64c_rsp_if import b64c_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/b64c_front.sv]
// ----------------------------------------------------------------------------
// b64c_front
// Accepts items, tracks group phase and carry, expands each item into words.
// ----------------------------------------------------------------------------
`default_nettype none

module b64c_front import b64c_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   b64c_req_if.sink        req_chan,
   input  wire logic       csr_write_en,
   input  wire logic       csr_write_data,
   input  wire logic       queue_full,
   output logic            push,
   output cmd_type         cmd,
   output front_status_type status
);

   phase_type  phase_ff, phase_in;
   logic [5:0] carry_ff, carry_in;
   dir_type    dir_ff;

   logic       accept;
   logic       produce;
   logic [7:0] b;
   logic       last;
   sextet_type dec;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && !queue_full;
   assign push           = accept && produce;
   assign b              = req_chan.data.in_value;
   assign last           = req_chan.data.in_last;
   assign dec            = dec_char(b);
   assign status         = '{phase: phase_ff, direction: dir_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_START;
         carry_ff <= '0;
         dir_ff   <= DIR_ENCODE;
      end else if (csr_write_en) begin
         phase_ff <= PHASE_START;
         carry_ff <= '0;
         dir_ff   <= dir_type'(csr_write_data);
      end else if (accept) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

   always_comb begin
      cmd      = '0;
      produce  = 1'b0;
      phase_in = phase_ff;
      carry_in = carry_ff;
      if (dir_ff == DIR_ENCODE) begin
         produce = 1'b1;
         unique case (phase_ff)
            PHASE_ONE: begin
               cmd.res[0]    = data_word(enc_char({carry_ff[1:0], b[7:4]}));
               carry_in      = {2'b00, b[3:0]};
               phase_in      = PHASE_TWO;
               cmd.final_idx = RIDX_W'(0);
            end
            PHASE_TWO: begin
               cmd.res[0]    = data_word(enc_char({carry_ff[3:0], b[7:6]}));
               cmd.res[1]    = data_word(enc_char(b[5:0]));
               carry_in      = '0;
               phase_in      = PHASE_START;
               cmd.final_idx = RIDX_W'(1);
            end
            PHASE_START, PHASE_THREE: begin
               cmd.res[0]    = data_word(enc_char(b[7:2]));
               carry_in      = {4'b0000, b[1:0]};
               phase_in      = PHASE_ONE;
               cmd.final_idx = RIDX_W'(0);
            end
         endcase
         if (last) begin
            // flush leftover bits with zero fill, then pad to a group of four
            if (phase_in == PHASE_ONE) begin
               cmd.res[1]    = data_word(enc_char({carry_in[1:0], 4'b0000}));
               cmd.res[2]    = data_word(PAD_CHAR);
               cmd.res[3]    = data_word(PAD_CHAR);
               cmd.final_idx = RIDX_W'(3);
            end else if (phase_in == PHASE_TWO) begin
               cmd.res[1]    = data_word(enc_char({carry_in[3:0], 2'b00}));
               cmd.res[2]    = data_word(PAD_CHAR);
               cmd.final_idx = RIDX_W'(2);
            end
            cmd.res[cmd.final_idx].out_last = 1'b1;
         end
      end else begin
         cmd.final_idx = RIDX_W'(0);
         if (!dec.hit && b != PAD_CHAR) begin
            // outside the alphabet: flag and skip
            cmd.res[0] = '{out_value: 8'h00, out_valid: 1'b0, out_last: last, bad_char: 1'b1};
            produce    = 1'b1;
         end else if (dec.hit) begin
            unique case (phase_ff)
               PHASE_START: begin
                  carry_in = dec.sextet;
                  phase_in = PHASE_ONE;
               end
               PHASE_ONE: begin
                  cmd.res[0] = data_word({carry_ff[5:0], dec.sextet[5:4]});
                  carry_in   = {2'b00, dec.sextet[3:0]};
                  phase_in   = PHASE_TWO;
                  produce    = 1'b1;
               end
               PHASE_TWO: begin
                  cmd.res[0] = data_word({carry_ff[3:0], dec.sextet[5:2]});
                  carry_in   = {4'b0000, dec.sextet[1:0]};
                  phase_in   = PHASE_THREE;
                  produce    = 1'b1;
               end
               PHASE_THREE: begin
                  cmd.res[0] = data_word({carry_ff[1:0], dec.sextet});
                  carry_in   = '0;
                  phase_in   = PHASE_START;
                  produce    = 1'b1;
               end
            endcase
            if (last) begin
               if (produce) begin
                  cmd.res[0].out_last = 1'b1;
               end else begin
                  cmd.res[0] = '{out_value: 8'h00, out_valid: 1'b0, out_last: 1'b1,
                                 bad_char: 1'b0};
                  produce    = 1'b1;
               end
            end
         end else if (last) begin
            // padding on the final item: bare end marker
            cmd.res[0] = '{out_value: 8'h00, out_valid: 1'b0, out_last: 1'b1, bad_char: 1'b0};
            produce    = 1'b1;
         end
      end
      if (last) begin
         phase_in = PHASE_START;
         carry_in = '0;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/b64c_queue.sv]
// ----------------------------------------------------------------------------
// b64c_queue
// Short queue of expanded items between the front and back halves.
// ----------------------------------------------------------------------------
`default_nettype none

module b64c_queue import b64c_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  cmd_type      push_cmd,
   input  wire logic    pop,
   output logic         full,
   output logic         head_valid,
   output cmd_type      head_cmd
);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;
   logic               do_push, do_pop;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      if (p == QPTR_W'(QUEUE_DEPTH - 1))
         return '0;
      else
         return QPTR_W'(p + 1'b1);
   endfunction

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= next_ptr(wr_ptr_ff);
         if (do_pop)  rd_ptr_ff <= next_ptr(rd_ptr_ff);
         if (do_push && !do_pop)
            count_ff <= QCNT_W'(count_ff + 1'b1);
         else if (do_pop && !do_push)
            count_ff <= QCNT_W'(count_ff - 1'b1);
      end
   end

endmodule

`default_nettype wire

[hw/rtl/b64c_back.sv]
// ----------------------------------------------------------------------------
// b64c_back
// Serialises the words of each queued item onto the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module b64c_back import b64c_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    head_valid,
   input  cmd_type      head_cmd,
   output logic         pop,
   b64c_rsp_if.source   rsp_chan
);

   logic [RIDX_W-1:0] idx_ff, idx_in;
   logic              take;

   assign rsp_chan.valid = head_valid;
   assign rsp_chan.data  = head_cmd.res[idx_ff];
   assign take           = head_valid && rsp_chan.ready;
   assign pop            = take && (idx_ff == head_cmd.final_idx);

   always_comb begin
      idx_in = idx_ff;
      if (pop)
         idx_in = '0;
      else if (take)
         idx_in = RIDX_W'(idx_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/base64_codec_unit.sv]
// ----------------------------------------------------------------------------
// base64_codec_unit
// Streaming base64 encoder/decoder (standard alphabet, '=' padding).
// ----------------------------------------------------------------------------
// A write on the csr port selects the direction (0 encode, 1 decode) and
// starts a new message. In encode mode each request word is a byte and gives
// one or two characters; the word marked last also gives any zero-filled
// flush character and '=' padding that its group needs. In decode mode each request word is a
// character: '=' is skipped, characters outside the alphabet give one word
// with bad_char set, and every sextet after the first of a group of four
// gives a byte. A last request always ends in a response word with out_last
// set, a bare marker with out_valid low if no data is left to carry it.
// The front half takes a request in every cycle while its two-entry queue has
// room; the back half sends one response word per cycle while the response
// port is ready, so throughput is set by the response port: an item gives one
// or two words per byte when encoding, with up to four words for a final
// encode byte, and at most one word per character when decoding.
// Each accepted item is registered in the queue before its first response word.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_codec_unit import b64c_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   b64c_req_if.sink   req_chan,
   b64c_rsp_if.source rsp_chan,
   input  wire logic  csr_write_en,
   input  wire logic  csr_write_data
);

   // front to queue
   logic             push;
   cmd_type          push_cmd;
   front_status_type front_status;

   // queue to back
   logic             queue_full;
   logic             head_valid;
   cmd_type          head_cmd;
   logic             pop;

   // Classify each request, advance phase and carry, expand into words
   b64c_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .queue_full     (queue_full),
      .push           (push),
      .cmd            (push_cmd),
      .status         (front_status)
   );

   // Hold expanded items so each side can stall on its own
   b64c_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Drain the head item one word per cycle while the response port is ready
   b64c_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

   // Non-data words carry a zero value
   ap_nodata_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.data.out_valid |-> rsp_chan.data.out_value == 8'h00)
      else $error("non-data response word carries a value");

   // A flagged character never carries data
   ap_bad_nodata: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.data.bad_char |-> !rsp_chan.data.out_valid)
      else $error("bad character word marked as data");

   // A csr write restarts the group
   ap_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      csr_write_en |=> front_status.phase == PHASE_START)
      else $error("group phase not cleared by csr write");

   // The front never pushes into a full queue
   ap_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("push into full queue");

endmodule

`default_nettype wire
